/* src/ws2812_pixel_serializer_unit_defines.svh */
// Assertion helpers for the checker of the LED strip serializer.
`ifndef WS2812_PIXEL_SERIALIZER_UNIT_DEFINES_SVH
`define WS2812_PIXEL_SERIALIZER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WPS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// The consequent must hold after the antecedent, later than in WPS_ASSERT_NEXT.
`define WPS_ASSERT_TWO(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
      else $error(msg);

`endif

/* src/wps_pkg.sv */
package wps_pkg;

   // Operation codes of an input word.
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_START = 2'd2;

   // Configuration register indexes.
   localparam logic [2:0] REG_ONE_HIGH  = 3'd0;
   localparam logic [2:0] REG_ONE_LOW   = 3'd1;
   localparam logic [2:0] REG_ZERO_HIGH = 3'd2;
   localparam logic [2:0] REG_ZERO_LOW  = 3'd3;
   localparam logic [2:0] REG_LATCH_GAP = 3'd4;
   localparam logic [2:0] REG_ACTIVE    = 3'd5;

   // Register reset values.
   localparam logic [7:0]  RST_ONE_HIGH  = 8'd26;
   localparam logic [7:0]  RST_ONE_LOW   = 8'd14;
   localparam logic [7:0]  RST_ZERO_HIGH = 8'd13;
   localparam logic [7:0]  RST_ZERO_LOW  = 8'd27;
   localparam logic [13:0] RST_LATCH_GAP = 14'd9600;
   localparam logic [3:0]  RST_ACTIVE    = 4'd3;

   // Bits sent per pixel, green then red then blue.
   localparam logic [4:0] BITS_PER_PIXEL = 5'd24;

   // Line sequencer phases.
   typedef enum logic [3:0] {
      PH_IDLE  = 4'b0001,
      PH_HIGH  = 4'b0010,
      PH_LOW   = 4'b0100,
      PH_LATCH = 4'b1000
   } wps_phase_type;

   // Configuration register file contents.
   typedef struct packed {
      logic [7:0]  one_high;
      logic [7:0]  one_low;
      logic [7:0]  zero_high;
      logic [7:0]  zero_low;
      logic [13:0] latch_gap;
      logic [3:0]  active_leds;
   } wps_cfg_type;

   // One input word.
   typedef struct packed {
      logic [1:0] operation;
      logic [2:0] led_slot;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } wps_item_type;

   // A zero pulse or gap length counts as one tick.
   function automatic logic [13:0] at_least_one(input logic [13:0] v);
      at_least_one = (v == 14'd0) ? 14'd1 : v;
   endfunction

endpackage

/* src/wps_store.sv */
module wps_store #(
   parameter int MAX_LEDS = 8,
   parameter int AW       = 3
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [23:0]   wr_data,
   output logic [23:0]   rd_data
);

   logic [23:0]         mem_ff [MAX_LEDS];
   logic [MAX_LEDS-1:0] vld_ff;
   logic [MAX_LEDS-1:0] vld_in;
   logic [23:0]         rd_data_ff;
   logic                rd_vld_ff;

   // Pixel memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   // Entry valid bits stand in for clearing the memory at reset.
   always_comb begin
      vld_in = vld_ff;
      if (wr_en) begin
         vld_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
         if (rd_en) begin
            rd_vld_ff <= vld_ff[rd_addr];
         end
      end
   end

   // An entry never written reads as black.
   assign rd_data = rd_vld_ff ? rd_data_ff : 24'd0;

endmodule

/* src/wps_engine.sv */
module wps_engine #(
   parameter int MAX_LEDS = 8,
   parameter int AW       = 3
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  wps_pkg::wps_item_type req,
   input  wps_pkg::wps_cfg_type  cfg,
   output logic                  rd_en,
   output logic [AW-1:0]         rd_addr,
   input  logic [23:0]           rd_data,
   output logic                  wr_en,
   output logic [AW-1:0]         wr_addr,
   output logic [23:0]           wr_data,
   output logic                  rsp_strobe,
   output logic                  rsp_data_line,
   output logic                  rsp_busy_res
);

   localparam logic [3:0] MAX_CLIP = 4'((MAX_LEDS > 15) ? 15 : MAX_LEDS);

   logic                  exec_ff;
   wps_pkg::wps_item_type item_ff;
   wps_pkg::wps_phase_type phase_ff, phase_in;
   logic [13:0]           tick_ff, tick_in;
   logic [4:0]            bit_ff, bit_in;
   logic [3:0]            ptr_ff, ptr_in;
   logic [23:0]           shift_ff, shift_in;
   logic                  strobe_ff;
   logic                  line_ff;
   logic                  busy_res_ff;

   logic                  accept;
   logic [3:0]            led_count;
   logic [4:0]            ptr_next;
   logic [AW+4:0]         ptr_wide;
   logic [AW+2:0]         idx_wide;
   logic                  idx_ok;
   logic [23:0]           shifted;
   logic [4:0]            bit_next;

   assign accept = start && !exec_ff;
   assign busy   = exec_ff;

   // Number of pixels per frame, at least one and at most the store depth.
   always_comb begin
      led_count = (cfg.active_leds == 4'd0) ? 4'd1 : cfg.active_leds;
      if (int'(led_count) > MAX_LEDS) begin
         led_count = MAX_CLIP;
      end
   end

   // Read address: pixel zero for a start or past the store end, otherwise the next pixel ahead.
   assign ptr_next = {1'b0, ptr_ff} + 5'd1;
   assign ptr_wide = {{AW{1'b0}}, ptr_next};
   assign rd_en    = accept;
   always_comb begin
      if (req.operation == wps_pkg::OP_START || int'(ptr_next) >= MAX_LEDS) begin
         rd_addr = '0;
      end else begin
         rd_addr = ptr_wide[AW-1:0];
      end
   end

   // Pixel write port.
   assign idx_wide = {{AW{1'b0}}, item_ff.led_slot};
   assign idx_ok   = ({1'b0, item_ff.led_slot} < led_count)
                     && (int'(item_ff.led_slot) < MAX_LEDS);
   assign wr_addr  = idx_wide[AW-1:0];
   assign wr_data  = {item_ff.green, item_ff.red, item_ff.blue};

   assign shifted  = {shift_ff[22:0], 1'b0};
   assign bit_next = bit_ff + 5'd1;

   // Sequencer step for the word in execution.
   always_comb begin
      phase_in = phase_ff;
      tick_in  = tick_ff;
      bit_in   = bit_ff;
      ptr_in   = ptr_ff;
      shift_in = shift_ff;
      wr_en    = 1'b0;
      if (exec_ff) begin
         unique case (item_ff.operation)
            wps_pkg::OP_TICK: begin
               if (phase_ff != wps_pkg::PH_IDLE && tick_ff > 14'd1) begin
                  tick_in = tick_ff - 14'd1;
               end else begin
                  unique case (phase_ff)
                     wps_pkg::PH_IDLE: begin
                        phase_in = wps_pkg::PH_IDLE;
                     end
                     wps_pkg::PH_HIGH: begin
                        phase_in = wps_pkg::PH_LOW;
                        tick_in  = wps_pkg::at_least_one({6'd0, shift_ff[23] ?
                                   cfg.one_low : cfg.zero_low});
                     end
                     wps_pkg::PH_LOW: begin
                        if (bit_next >= wps_pkg::BITS_PER_PIXEL) begin
                           ptr_in = ptr_next[3:0];
                           if (ptr_next >= {1'b0, led_count}) begin
                              phase_in = wps_pkg::PH_LATCH;
                              tick_in  = wps_pkg::at_least_one(cfg.latch_gap);
                              bit_in   = 5'd0;
                              shift_in = shifted;
                           end else begin
                              phase_in = wps_pkg::PH_HIGH;
                              shift_in = rd_data;
                              bit_in   = 5'd0;
                              tick_in  = wps_pkg::at_least_one({6'd0, rd_data[23] ?
                                         cfg.one_high : cfg.zero_high});
                           end
                        end else begin
                           phase_in = wps_pkg::PH_HIGH;
                           shift_in = shifted;
                           bit_in   = bit_next;
                           tick_in  = wps_pkg::at_least_one({6'd0, shifted[23] ?
                                      cfg.one_high : cfg.zero_high});
                        end
                     end
                     wps_pkg::PH_LATCH: begin
                        phase_in = wps_pkg::PH_IDLE;
                        tick_in  = 14'd0;
                        ptr_in   = 4'd0;
                        bit_in   = 5'd0;
                     end
                     default: begin
                        phase_in = wps_pkg::PH_IDLE;
                     end
                  endcase
               end
            end
            wps_pkg::OP_WRITE: begin
               wr_en = (phase_ff == wps_pkg::PH_IDLE) && idx_ok;
            end
            wps_pkg::OP_START: begin
               if (phase_ff == wps_pkg::PH_IDLE) begin
                  phase_in = wps_pkg::PH_HIGH;
                  ptr_in   = 4'd0;
                  bit_in   = 5'd0;
                  shift_in = rd_data;
                  tick_in  = wps_pkg::at_least_one({6'd0, rd_data[23] ?
                             cfg.one_high : cfg.zero_high});
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   // Item capture.
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req;
      end
   end

   // Sequencer state, execution flag and result strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         exec_ff   <= 1'b0;
         phase_ff  <= wps_pkg::PH_IDLE;
         tick_ff   <= 14'd0;
         bit_ff    <= 5'd0;
         ptr_ff    <= 4'd0;
         shift_ff  <= 24'd0;
         strobe_ff <= 1'b0;
      end else begin
         exec_ff   <= accept;
         phase_ff  <= phase_in;
         tick_ff   <= tick_in;
         bit_ff    <= bit_in;
         ptr_ff    <= ptr_in;
         shift_ff  <= shift_in;
         strobe_ff <= exec_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_ff) begin
         line_ff     <= (phase_in == wps_pkg::PH_HIGH);
         busy_res_ff <= (phase_in != wps_pkg::PH_IDLE);
      end
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_data_line = line_ff;
   assign rsp_busy_res  = busy_res_ff;

endmodule

/* src/ws2812_pixel_serializer_unit.sv */
// A word is taken when start is high and busy is low; busy then stays high
// while the pixel memory read completes and the word executes, so no new word
// is taken before the last one is through. The result word is registered from
// the executing word and is marked by rsp_strobe; the receiver cannot stall it.
// Synchronous active-high reset sets the configuration registers to their
// defaults, idles the line sequencer and marks every pixel black via valid bits.
module ws2812_pixel_serializer_unit #(
   parameter int MAX_LEDS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_operation,
   input  logic [2:0]  req_led_slot,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   output logic        rsp_strobe,
   output logic        rsp_data_line,
   output logic        rsp_busy_res,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [13:0] csr_data
);

   localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;

   wps_pkg::wps_cfg_type  cfg_ff;
   wps_pkg::wps_cfg_type  cfg_in;
   wps_pkg::wps_item_type req;
   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   logic [23:0]           rd_data;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [23:0]           wr_data;

   assign csr_ready = 1'b1;

   // Register file write decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            wps_pkg::REG_ONE_HIGH:  cfg_in.one_high    = csr_data[7:0];
            wps_pkg::REG_ONE_LOW:   cfg_in.one_low     = csr_data[7:0];
            wps_pkg::REG_ZERO_HIGH: cfg_in.zero_high   = csr_data[7:0];
            wps_pkg::REG_ZERO_LOW:  cfg_in.zero_low    = csr_data[7:0];
            wps_pkg::REG_LATCH_GAP: cfg_in.latch_gap   = csr_data;
            wps_pkg::REG_ACTIVE:    cfg_in.active_leds = csr_data[3:0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.one_high    <= wps_pkg::RST_ONE_HIGH;
         cfg_ff.one_low     <= wps_pkg::RST_ONE_LOW;
         cfg_ff.zero_high   <= wps_pkg::RST_ZERO_HIGH;
         cfg_ff.zero_low    <= wps_pkg::RST_ZERO_LOW;
         cfg_ff.latch_gap   <= wps_pkg::RST_LATCH_GAP;
         cfg_ff.active_leds <= wps_pkg::RST_ACTIVE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req.operation = req_operation;
   assign req.led_slot  = req_led_slot;
   assign req.red       = req_red;
   assign req.green     = req_green;
   assign req.blue      = req_blue;

   wps_engine #(
      .MAX_LEDS (MAX_LEDS),
      .AW       (AW)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req           (req),
      .cfg           (cfg_ff),
      .rd_en         (rd_en),
      .rd_addr       (rd_addr),
      .rd_data       (rd_data),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .rsp_strobe    (rsp_strobe),
      .rsp_data_line (rsp_data_line),
      .rsp_busy_res  (rsp_busy_res)
   );

   wps_store #(
      .MAX_LEDS (MAX_LEDS),
      .AW       (AW)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

endmodule

/* src/wps_checker.sv */
`include "ws2812_pixel_serializer_unit_defines.svh"

module wps_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_strobe,
   input logic rsp_data_line,
   input logic rsp_busy_res
);

   logic accepted;
   logic line_high;

   // Input handshake and a high line level inside a result word.
   assign accepted  = start && !busy;
   assign line_high = rsp_strobe && rsp_data_line;

   // An accepted word raises busy in the cycle after, holding off the next one.
   `WPS_ASSERT_NEXT(a_accept_busy, clock, reset, accepted, busy, "busy missing after accept")

   // Every accepted word is followed by its result word.
   `WPS_ASSERT_TWO(a_accept_result, clock, reset, accepted, rsp_strobe, "result word missing")

   // A result word never lasts longer than one cycle.
   `WPS_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_strobe, !rsp_strobe, "strobe held too long")

   // A high line level only occurs inside a running frame.
   `WPS_ASSERT_SAME(a_line_in_frame, clock, reset, line_high, rsp_busy_res, "line high while idle")

endmodule

bind ws2812_pixel_serializer_unit wps_checker u_wps_checker (.*);
